// File: src/ciro_pkg.sv
package ciro_pkg;

  localparam int unsigned FuncW = 4;
  localparam int unsigned LenW  = 28;
  localparam int unsigned PosW  = 31;
  localparam int unsigned PtrW  = 32;
  localparam int unsigned OfsW  = 31;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 64;

  // cigar op codes
  localparam logic [FuncW-1:0] OP_M = 4'd0;
  localparam logic [FuncW-1:0] OP_I = 4'd1;
  localparam logic [FuncW-1:0] OP_D = 4'd2;
  localparam logic [FuncW-1:0] OP_N = 4'd3;
  localparam logic [FuncW-1:0] OP_S = 4'd4;
  localparam logic [FuncW-1:0] OP_H = 4'd5;
  localparam logic [FuncW-1:0] OP_P = 4'd6;
  localparam logic [FuncW-1:0] OP_EQ = 4'd7;
  localparam logic [FuncW-1:0] OP_X = 4'd8;

  localparam logic [OfsW-1:0] OfsMax = {OfsW{1'b1}};
  localparam logic [PtrW-1:0] PtrMax = {PtrW{1'b1}};

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [LenW-1:0]  op_length;
    logic             first_op;
    logic             last_op;
    logic [PosW-1:0]  align_pos;
    logic [PtrW-1:0]  eff_start;
    logic [PtrW-1:0]  eff_end;
    logic             active;
  } op_t;

  typedef struct packed {
    logic            left_found;
    logic [OfsW-1:0] left_index;
    logic            right_found;
    logic [OfsW-1:0] right_index;
  } res_t;

  function automatic logic [PtrW-1:0] sat_ptr(input logic [PtrW:0] v);
    sat_ptr = v[PtrW] ? PtrMax : v[PtrW-1:0];
  endfunction

  function automatic logic [OfsW-1:0] sat_ofs(input logic [PtrW:0] v);
    sat_ofs = (v[PtrW:OfsW] != '0) ? OfsMax : v[OfsW-1:0];
  endfunction

endpackage

// File: src/cigar_interval_to_read_offsets.sv
// Maps a reference interval onto read offsets by walking the CIGAR ops of one
// aligned read, one op per input beat. The first beat (tuser high) also
// carries the alignment position and the interval; the start is raised to the
// alignment position and a zero-length interval is widened by one. One result beat
// comes out for each beat with tlast high, holding the first read offsets at
// which the reference reaches the interval start and end. An op is accepted
// into the input register; as it leaves that register the core updates its
// pointers and bound checks and a tlast op loads the result register, so the
// result beat passes through the input register and then the result register.
// A new op can be taken in every cycle unless a tlast op waits in the input
// register, which happens only while the result register holds an untaken beat.
module cigar_interval_to_read_offsets (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[3:0], op_length[31:4], align_pos[62:32], range_start[93:63],
  // range_end[124:94], zero[127:125]
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // first_op[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_found[0], left_index[31:1], right_found[32], right_index[63:33]
  output logic [63:0]  m_axis_tdata
);

  logic           op_valid, op_take, res_load, res_ready;
  ciro_pkg::op_t  op;
  ciro_pkg::res_t res;

  ciro_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .first_i (s_axis_tuser),
    .last_i  (s_axis_tlast),
    .valid_o (op_valid),
    .op_o    (op),
    .take_i  (op_take)
  );

  ciro_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (op_valid),
    .op_i        (op),
    .res_ready_i (res_ready),
    .take_o      (op_take),
    .res_load_o  (res_load),
    .res_o       (res)
  );

  ciro_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_load),
    .res_i      (res),
    .can_load_o (res_ready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (m_axis_tdata)
  );

endmodule

// File: src/ciro_in_reg.sv
module ciro_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [ciro_pkg::InDataW-1:0] data_i,
  input  logic                       first_i,
  input  logic                       last_i,
  output logic                       valid_o,
  output ciro_pkg::op_t              op_o,
  input  logic                       take_i
);

  logic                              valid_q, valid_d;
  ciro_pkg::op_t                     op_q, op_d;
  logic [ciro_pkg::PosW-1:0]         pos, rs, re, s_clamp;
  logic [ciro_pkg::PtrW-1:0]         e_wide;

  assign pos = data_i[62:32];
  assign rs  = data_i[93:63];
  assign re  = data_i[124:94];

  // clamp start to the alignment position, widen a zero-length interval by one
  always_comb begin
    s_clamp = (rs < pos) ? pos : rs;
    e_wide  = (s_clamp == re) ? ({1'b0, s_clamp} + 32'd1) : {1'b0, re};
  end

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (valid_i && ready_o) begin
      valid_d          = 1'b1;
      op_d.func        = data_i[3:0];
      op_d.op_length   = data_i[31:4];
      op_d.first_op    = first_i;
      op_d.last_op     = last_i;
      op_d.align_pos   = pos;
      op_d.eff_start   = {1'b0, s_clamp};
      op_d.eff_end     = e_wide;
      op_d.active      = {1'b0, s_clamp} < e_wide;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

// File: src/ciro_core.sv
module ciro_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  ciro_pkg::op_t op_i,
  input  logic          res_ready_i,
  output logic          take_o,
  output logic          res_load_o,
  output ciro_pkg::res_t res_o
);

  localparam int unsigned PtrW = ciro_pkg::PtrW;
  localparam int unsigned OfsW = ciro_pkg::OfsW;

  logic [PtrW-1:0] rp_q, rp_d, sp_q, sp_d, st_q, st_d, en_q, en_d;
  logic            act_q, act_d, ls_q, ls_d, rs_q, rs_d;
  logic [OfsW-1:0] lo_q, lo_d, ro_q, ro_d;

  logic [PtrW-1:0] rp0, sp0, st0, en0, rp1, sp1, kl, kr;
  logic            act0, ls0, rs0;
  logic [OfsW-1:0] lo0, ro0;
  logic [PtrW:0]   rp_sum, sp_sum;
  logic            is_run, adv_ref, adv_seq, l_hit, r_hit, fire, ld;
  logic [OfsW-1:0] l_ofs, r_ofs;

  // non-last beats never wait on the result side
  assign fire   = valid_i && (!op_i.last_op || res_ready_i);
  assign take_o = fire;
  assign ld     = op_i.first_op;

  always_comb begin
    rp0  = ld ? {1'b0, op_i.align_pos} : rp_q;
    sp0  = ld ? '0 : sp_q;
    st0  = ld ? op_i.eff_start : st_q;
    en0  = ld ? op_i.eff_end : en_q;
    act0 = ld ? op_i.active : act_q;
    ls0  = ld ? 1'b0 : ls_q;
    rs0  = ld ? 1'b0 : rs_q;
    lo0  = ld ? '0 : lo_q;
    ro0  = ld ? '0 : ro_q;
  end

  always_comb begin
    is_run  = 1'b0;
    adv_ref = 1'b0;
    adv_seq = 1'b0;
    case (op_i.func)
      ciro_pkg::OP_M, ciro_pkg::OP_EQ, ciro_pkg::OP_X: begin
        is_run = 1'b1;
      end
      ciro_pkg::OP_I, ciro_pkg::OP_S: begin
        adv_seq = 1'b1;
      end
      ciro_pkg::OP_D, ciro_pkg::OP_N: begin
        adv_ref = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rp_sum = {1'b0, rp0} + {{(PtrW-ciro_pkg::LenW+1){1'b0}}, op_i.op_length};
  assign sp_sum = {1'b0, sp0} + {{(PtrW-ciro_pkg::LenW+1){1'b0}}, op_i.op_length};

  always_comb begin
    rp1 = (is_run || adv_ref) ? ciro_pkg::sat_ptr(rp_sum) : rp0;
    sp1 = (is_run || adv_seq) ? ciro_pkg::sat_ptr(sp_sum) : sp0;
    // distance into the run where the reference pointer meets each bound
    kl  = (st0 > rp0) ? (st0 - rp0) : PtrW'(1);
    kr  = (en0 > rp0) ? (en0 - rp0) : PtrW'(1);
    if (is_run) begin
      l_hit = act0 && !ls0 && (op_i.op_length != '0) && (rp_sum >= {1'b0, st0});
      r_hit = act0 && !rs0 && (op_i.op_length != '0) && (rp_sum >= {1'b0, en0});
      l_ofs = ciro_pkg::sat_ofs({1'b0, sp0} + {1'b0, kl});
      r_ofs = ciro_pkg::sat_ofs({1'b0, sp0} + {1'b0, kr});
    end else begin
      l_hit = act0 && !ls0 && (rp1 >= st0);
      r_hit = act0 && !rs0 && (rp1 >= en0);
      l_ofs = ciro_pkg::sat_ofs({1'b0, sp1});
      r_ofs = ciro_pkg::sat_ofs({1'b0, sp1});
    end
  end

  always_comb begin
    rp_d  = rp_q;
    sp_d  = sp_q;
    st_d  = st_q;
    en_d  = en_q;
    act_d = act_q;
    ls_d  = ls_q;
    rs_d  = rs_q;
    lo_d  = lo_q;
    ro_d  = ro_q;
    if (fire) begin
      rp_d  = rp1;
      sp_d  = sp1;
      st_d  = st0;
      en_d  = en0;
      act_d = act0;
      ls_d  = ls0 || l_hit;
      rs_d  = rs0 || r_hit;
      lo_d  = l_hit ? l_ofs : lo0;
      ro_d  = r_hit ? r_ofs : ro0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      sp_q  <= '0;
      st_q  <= '0;
      en_q  <= '0;
      act_q <= 1'b0;
      ls_q  <= 1'b0;
      rs_q  <= 1'b0;
      lo_q  <= '0;
      ro_q  <= '0;
    end else begin
      rp_q  <= rp_d;
      sp_q  <= sp_d;
      st_q  <= st_d;
      en_q  <= en_d;
      act_q <= act_d;
      ls_q  <= ls_d;
      rs_q  <= rs_d;
      lo_q  <= lo_d;
      ro_q  <= ro_d;
    end
  end

  assign res_load_o        = fire && op_i.last_op;
  assign res_o.left_found  = ls_d;
  assign res_o.left_index  = ls_d ? lo_d : '0;
  assign res_o.right_found = rs_d;
  assign res_o.right_index = rs_d ? ro_d : '0;

  a_inactive_no_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_q |-> !ls_q && !rs_q)
    else $error("bound marked seen on an inactive interval");

  a_left_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_q && !(fire && op_i.first_op) |=> ls_q && $stable(lo_q))
    else $error("left offset changed after it was found");

  a_right_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_q && !(fire && op_i.first_op) |=> rs_q && $stable(ro_q))
    else $error("right offset changed after it was found");

  a_ref_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && op_i.first_op) |=> rp_q >= $past(rp_q) && sp_q >= $past(sp_q))
    else $error("pointer moved backward within a read");

endmodule

// File: src/ciro_out_reg.sv
module ciro_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  ciro_pkg::res_t                res_i,
  output logic                          can_load_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ciro_pkg::OutDataW-1:0] data_o
);

  logic           valid_q, valid_d;
  ciro_pkg::res_t res_q, res_d;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign data_o  = {res_q.right_index, res_q.right_found, res_q.left_index, res_q.left_found};

endmodule

// File: dv/cigar_interval_to_read_offsets_tb.sv
module cigar_interval_to_read_offsets_tb;

  localparam int unsigned FuncW    = ciro_pkg::FuncW;
  localparam int unsigned LenW     = ciro_pkg::LenW;
  localparam int unsigned PosW     = ciro_pkg::PosW;
  localparam int unsigned PtrW     = ciro_pkg::PtrW;
  localparam int unsigned OfsW     = ciro_pkg::OfsW;
  localparam int unsigned InDataW  = ciro_pkg::InDataW;
  localparam int unsigned OutDataW = ciro_pkg::OutDataW;
  localparam logic [OfsW-1:0] OfsMax = ciro_pkg::OfsMax;
  localparam logic [PtrW-1:0] PtrMax = ciro_pkg::PtrMax;

  typedef ciro_pkg::res_t res_t;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [FuncW-1:0] OpRsvdLo = 4'd9;
  localparam logic [FuncW-1:0] OpRsvdHi = 4'd15;

  class offset_scoreboard;
    logic [PtrW-1:0] ref_ptr;
    logic [PtrW-1:0] seq_ptr;
    logic [PtrW-1:0] lo_bound;
    logic [PtrW-1:0] hi_bound;
    bit              active;
    bit              left_hit;
    bit              right_hit;
    logic [OfsW-1:0] left_ofs;
    logic [OfsW-1:0] right_ofs;
    res_t            expected_offsets[$];
    int              fail_count;
    int              results_seen;
    int              both_found;

    function new();
      ref_ptr = '0;
      seq_ptr = '0;
      lo_bound = '0;
      hi_bound = '0;
      active = 1'b0;
      left_hit = 1'b0;
      right_hit = 1'b0;
      left_ofs = '0;
      right_ofs = '0;
      fail_count = 0;
      results_seen = 0;
      both_found = 0;
    endfunction

    function logic [PtrW-1:0] add_sat(logic [PtrW-1:0] a, logic [LenW-1:0] b);
      logic [PtrW:0] s;
      s = {1'b0, a} + (PtrW+1)'(b);
      return s[PtrW] ? PtrMax : s[PtrW-1:0];
    endfunction

    function logic [OfsW-1:0] clip_ofs(logic [63:0] v);
      return (v > 64'(OfsMax)) ? OfsMax : v[OfsW-1:0];
    endfunction

    // a run of len bases moves the reference from ref_ptr+1 up to ref_ptr+len
    function bit run_reaches(logic [PtrW-1:0] bound, logic [LenW-1:0] len);
      return (len != '0) && ((64'(ref_ptr) + 64'(len)) >= 64'(bound));
    endfunction

    function logic [OfsW-1:0] run_offset(logic [PtrW-1:0] bound);
      logic [63:0] k;
      k = (bound > ref_ptr) ? 64'(bound - ref_ptr) : 64'd1;
      return clip_ofs(64'(seq_ptr) + k);
    endfunction

    function void predict_offsets(logic [FuncW-1:0] func, logic [LenW-1:0] len,
                                  bit first, bit last, logic [PosW-1:0] pos,
                                  logic [PosW-1:0] r_start, logic [PosW-1:0] r_end);
      logic [PtrW-1:0] lo;
      logic [PtrW-1:0] hi;
      res_t            want;
      if (first) begin
        lo = {1'b0, r_start};
        hi = {1'b0, r_end};
        if (lo < {1'b0, pos}) lo = {1'b0, pos};
        if (lo == hi) hi = lo + 32'd1;
        ref_ptr = {1'b0, pos};
        seq_ptr = '0;
        lo_bound = lo;
        hi_bound = hi;
        active = lo < hi;
        left_hit = 1'b0;
        left_ofs = '0;
        right_hit = 1'b0;
        right_ofs = '0;
      end
      if (func == ciro_pkg::OP_M || func == ciro_pkg::OP_EQ || func == ciro_pkg::OP_X) begin
        if (active) begin
          if (!left_hit && run_reaches(lo_bound, len)) begin
            left_hit = 1'b1;
            left_ofs = run_offset(lo_bound);
          end
          if (!right_hit && run_reaches(hi_bound, len)) begin
            right_hit = 1'b1;
            right_ofs = run_offset(hi_bound);
          end
        end
        ref_ptr = add_sat(ref_ptr, len);
        seq_ptr = add_sat(seq_ptr, len);
      end else begin
        if (func == ciro_pkg::OP_I || func == ciro_pkg::OP_S) seq_ptr = add_sat(seq_ptr, len);
        else if (func == ciro_pkg::OP_D || func == ciro_pkg::OP_N)
          ref_ptr = add_sat(ref_ptr, len);
        if (active) begin
          if (!left_hit && ref_ptr >= lo_bound) begin
            left_hit = 1'b1;
            left_ofs = clip_ofs(64'(seq_ptr));
          end
          if (!right_hit && ref_ptr >= hi_bound) begin
            right_hit = 1'b1;
            right_ofs = clip_ofs(64'(seq_ptr));
          end
        end
      end
      if (last) begin
        want.left_found = left_hit;
        want.left_index = left_hit ? left_ofs : '0;
        want.right_found = right_hit;
        want.right_index = right_hit ? right_ofs : '0;
        expected_offsets = {expected_offsets, want};
      end
    endfunction

    task report(string msg);
      if (fail_count < 40) $display("mismatch: %s", msg);
      fail_count++;
    endtask

    task check_offsets(logic [OutDataW-1:0] d);
      res_t want;
      results_seen++;
      if (expected_offsets.size() == 0) begin
        report($sformatf("result beat %h with no read pending", d));
        return;
      end
      want = expected_offsets.pop_front();
      if (want.left_found && want.right_found) both_found++;
      if (d[0] !== want.left_found)
        report($sformatf("result %0d left_found %b, want %b", results_seen, d[0],
                         want.left_found));
      if (d[31:1] !== want.left_index)
        report($sformatf("result %0d left_index %0d, want %0d", results_seen, d[31:1],
                         want.left_index));
      if (d[32] !== want.right_found)
        report($sformatf("result %0d right_found %b, want %b", results_seen, d[32],
                         want.right_found));
      if (d[63:33] !== want.right_index)
        report($sformatf("result %0d right_index %0d, want %0d", results_seen, d[63:33],
                         want.right_index));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  offset_scoreboard offsets = new();
  int               send_idle_pct;
  int               recv_stall_pct;
  int               ops_sent;
  int               reads_sent;
  int unsigned      cycle_count;

  cigar_interval_to_read_offsets u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) offsets.check_offsets(m_axis_tdata);
    end
  end

  // one op beat, with random idle cycles ahead of it
  task automatic send_op(logic [FuncW-1:0] func, logic [LenW-1:0] len, bit first,
                         bit last, logic [PosW-1:0] pos, logic [PosW-1:0] r_start,
                         logic [PosW-1:0] r_end);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = {3'b000, r_end, r_start, pos, len, func};
    s_axis_tuser = first;
    s_axis_tlast = last;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    offsets.predict_offsets(func, len, first, last, pos, r_start, r_end);
    ops_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (offsets.expected_offsets.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [PosW-1:0] clamp_pos(longint v);
    if (v < 0) return '0;
    if (v > longint'(OfsMax)) return OfsMax;
    return v[PosW-1:0];
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return LenW'($urandom_range(40));
    if (sel < 9) return LenW'($urandom_range(2000));
    return LenW'($urandom);
  endfunction

  // one read: interval placed near the alignment so that match runs hit it
  task automatic send_read(bit keep_first, bit keep_last);
    int               n;
    int               sel;
    bit               big;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  r_start;
    logic [PosW-1:0]  r_end;
    logic [FuncW-1:0] func;
    logic [LenW-1:0]  len;
    big = ($urandom_range(99) < 2);
    n = big ? $urandom_range(34, 24) : $urandom_range(8, 1);
    sel = $urandom_range(9);
    if (sel < 5) pos = PosW'($urandom_range(1000));
    else if (sel < 8) pos = PosW'($urandom);
    else pos = OfsMax - PosW'($urandom_range(5000));
    sel = $urandom_range(9);
    if (sel < 9) r_start = clamp_pos(longint'(pos) + longint'($urandom_range(350)) - 50);
    else r_start = PosW'($urandom);
    sel = $urandom_range(9);
    if (sel == 0) r_end = r_start;
    else if (sel == 1) r_end = PosW'($urandom);
    else r_end = clamp_pos(longint'(r_start) + longint'($urandom_range(420)) - 20);
    for (int i = 0; i < n; i++) begin
      func = ($urandom_range(99) < 40) ? ciro_pkg::OP_M : FuncW'($urandom_range(15));
      len = big ? LenW'($urandom_range(28'hFFFFFFF, 28'h8000000)) : rand_len();
      if (i == 0) send_op(func, len, keep_first, keep_last && n == 1, pos, r_start, r_end);
      else send_op(func, len, 1'b0, keep_last && i == n - 1, PosW'($urandom),
                   PosW'($urandom), PosW'($urandom));
    end
    reads_sent++;
  endtask

  initial begin
    int idle_pct[4];
    int stall_pct[4];
    int phase_end;
    int sel;
    idle_pct = '{0, 87, 0, 36};
    stall_pct = '{0, 0, 87, 36};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ops_sent = 0;
    reads_sent = 0;
    cycle_count = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // op with no first beat straight after reset: interval still inactive
    send_op(ciro_pkg::OP_M, 28'd5, 1'b0, 1'b1, 31'd0, 31'd0, 31'd0);
    // single-op read, start clamped up to the alignment
    send_op(ciro_pkg::OP_M, 28'd30, 1'b1, 1'b1, 31'd100, 31'd50, 31'd120);
    // empty interval
    send_op(ciro_pkg::OP_M, 28'd10, 1'b1, 1'b1, 31'd0, 31'd200, 31'd100);
    // start equal to end gets widened by one
    send_op(ciro_pkg::OP_X, 28'd3, 1'b1, 1'b1, 31'd40, 31'd40, 31'd40);
    // every op code in one read, zero-length match included
    send_op(ciro_pkg::OP_S, 28'd4, 1'b1, 1'b0, 31'd1000, 31'd1003, 31'd1030);
    send_op(ciro_pkg::OP_M, 28'd0, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_M, 28'd2, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_I, 28'd3, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_D, 28'd2, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_N, 28'd5, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_H, 28'd7, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_P, 28'd9, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_EQ, 28'd10, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(ciro_pkg::OP_X, 28'd8, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(OpRsvdLo, 28'd3, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0);
    send_op(OpRsvdHi, 28'd6, 1'b0, 1'b1, 31'd0, 31'd0, 31'd0);
    // long insertions push the read offset past the 31-bit maximum
    send_op(ciro_pkg::OP_I, 28'hFFFFFFF, 1'b1, 1'b0, 31'h7FFFFF00, OfsMax, OfsMax);
    repeat (8) send_op(ciro_pkg::OP_I, 28'hFFFFFFF, 1'b0, 1'b0, OfsMax, OfsMax, OfsMax);
    send_op(ciro_pkg::OP_M, 28'hFFFFFFF, 1'b0, 1'b1, OfsMax, OfsMax, OfsMax);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      phase_end = ops_sent + 250;
      while (ops_sent < phase_end) begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          send_op(FuncW'($urandom), LenW'($urandom), $urandom_range(1), $urandom_range(1),
                  PosW'($urandom), PosW'($urandom), PosW'($urandom));
        end else if (sel < 12) begin
          send_read(1'b0, 1'b1);
        end else if (sel < 16) begin
          send_read(1'b1, 1'b0);
        end else begin
          send_read(1'b1, 1'b1);
        end
      end
      // hold off until every pending read has reported
      drain_results();
    end

    while (offsets.expected_offsets.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (offsets.expected_offsets.size() != 0)
      offsets.report($sformatf("%0d reads never reported", offsets.expected_offsets.size()));
    $display("walked %0d cigar ops in %0d reads over four idle/stall mixes", ops_sent,
             reads_sent);
    $display("checked %0d offset results, %0d with both bounds located",
             offsets.results_seen, offsets.both_found);
    if (offsets.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ciro_pkg.sv
src/ciro_in_reg.sv
src/ciro_core.sv
src/ciro_out_reg.sv
src/cigar_interval_to_read_offsets.sv
dv/cigar_interval_to_read_offsets_tb.sv
